FILE: hw/rtl/wcra_pkg.sv
package wcra_pkg;

    // Default depth of the pass history
    localparam int WINDOW_MAX_DEF = 512;

    // Field widths fixed by the stream format
    localparam int POS_W   = 32;
    localparam int SCORE_W = 32;
    localparam int WS_W    = 10;
    localparam int THR_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOD_CUTOFF         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COVERAGE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP            = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_START          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_END            = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GENETIC_MODE       = 3'd6;

    // Status of the history recount engine
    typedef struct packed {
        logic busy;
        logic load;
    } rc_stat_t;

endpackage

FILE: hw/rtl/window_coverage_run_assembler_unit.sv
// Window coverage run assembler.
// Input stream s_*: one locus per request, in order. s_tdata carries the
// physical position, genetic position and window score; s_tuser carries the
// sequence-start flag and the window-present flag; s_tlast marks the final
// locus. Result stream m_*: one request per reported run, carrying its start,
// stop and size. The user must see that configuration is written over cfg_*
// only while the block is idle; the block does not enforce this. A locus goes
// from the input register through the update step into the result register.
// One locus per cycle is taken while no recount runs and the receiver does
// not stall, set by the single update step between the two registers; the
// pass history lives in a ring memory with one write and one read port per
// cycle. A stalled receiver holds the result register; the input register
// still takes one more locus, then s_tready drops until the result is taken.
// Writing window_size starts a recount of n history entries with s_tready and
// cfg_ready low, n = min(clamped window size, loci seen in the sequence).
// Reset (aresetn low, synchronous) returns registers to their defaults and
// clears all run state; the history needs no clearing pass.
module window_coverage_run_assembler_unit #(
    parameter int WINDOW_MAX = wcra_pkg::WINDOW_MAX_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [95:0]                         s_tdata,  // phys_pos, gen_pos, window_score
    input  logic [1:0]                          s_tuser,  // first_locus, window_present
    input  logic                                s_tlast,  // last_locus
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [95:0]                         m_tdata,  // seg_start, seg_stop, seg_size
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wcra_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wcra_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int POS_W = wcra_pkg::POS_W;

    // Configuration registers
    logic signed [wcra_pkg::SCORE_W-1:0] cutoff_reg;
    logic [wcra_pkg::WS_W-1:0]           ws_reg;
    logic [wcra_pkg::THR_W-1:0]          thr_reg;
    logic [POS_W-1:0]                    max_gap_reg;
    logic [POS_W-1:0]                    gap_start_reg;
    logic [POS_W-1:0]                    gap_end_reg;
    logic                                genetic_reg;

    // Input register
    logic             in_vld_reg;
    logic             in_first_reg;
    logic             in_last_reg;
    logic [POS_W-1:0] in_phys_reg;
    logic [POS_W-1:0] in_gen_reg;
    logic             in_pass_reg;

    // Sequence state
    logic [CW-1:0]    count_reg;
    logic             run_active_reg;
    logic [POS_W-1:0] run_start_pos_reg;
    logic [31:0]      run_start_idx_reg;
    logic [31:0]      locus_idx_reg;
    logic [POS_W-1:0] prev_phys_reg;
    logic [POS_W-1:0] prev_rep_reg;

    // Result register
    logic             out_vld_reg;
    logic [POS_W-1:0] seg_start_reg;
    logic [POS_W-1:0] seg_stop_reg;
    logic [POS_W-1:0] seg_size_reg;

    logic                  in_accept;
    logic                  cfg_accept;
    logic                  proc_fire;
    logic                  s_pass;
    logic [CW-1:0]         ws_eff;
    logic [wcra_pkg::THR_W-1:0] thr_eff;
    logic                  old_bit;
    logic [CW-1:0]         rc_sum;
    wcra_pkg::rc_stat_t    rc_stat;

    // Update step signals
    logic             run_base;
    logic [POS_W-1:0] start_pos_base;
    logic [31:0]      start_idx_base;
    logic [31:0]      locus_base;
    logic [POS_W-1:0] prev_phys_base;
    logic [POS_W-1:0] prev_rep_base;
    logic [CW-1:0]    count_base;
    logic [CW-1:0]    count_next;
    logic [POS_W-1:0] rep;
    logic             covered;
    logic [POS_W-1:0] phys_step;
    logic             gap;
    logic             run_next;
    logic [POS_W-1:0] start_pos_next;
    logic [31:0]      start_idx_next;
    logic [31:0]      locus_next;
    logic             emit_req;
    logic [POS_W-1:0] emit_stop;
    logic [31:0]      emit_len;
    logic             do_emit;
    logic [POS_W+1:0] size_raw;
    logic [POS_W-1:0] size_sat;

    // Handshakes
    assign proc_fire  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready   = !rc_stat.busy && (!in_vld_reg || proc_fire);
    assign in_accept  = s_tvalid && s_tready;
    assign cfg_ready  = !rc_stat.busy;
    assign cfg_accept = cfg_valid && cfg_ready;

    // Clamp window size and threshold into their working ranges
    always_comb begin
        if (ws_reg == '0) begin
            ws_eff = CW'(1);
        end else if (32'(ws_reg) > WINDOW_MAX) begin
            ws_eff = CW'(WINDOW_MAX);
        end else begin
            ws_eff = CW'(ws_reg);
        end
        thr_eff = (thr_reg == '0) ? wcra_pkg::THR_W'(1) : thr_reg;
    end

    // Window pass decision at the input
    assign s_pass = s_tuser[1] && ($signed(s_tdata[95:64]) >= cutoff_reg);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg    <= '0;
            ws_reg        <= wcra_pkg::WS_W'(1);
            thr_reg       <= wcra_pkg::THR_W'(1);
            max_gap_reg   <= '0;
            gap_start_reg <= '0;
            gap_end_reg   <= '0;
            genetic_reg   <= 1'b0;
        end else if (cfg_accept) begin
            unique case (cfg_index)
                wcra_pkg::REG_LOD_CUTOFF:         cutoff_reg    <= $signed(cfg_data);
                wcra_pkg::REG_WINDOW_SIZE:        ws_reg        <= cfg_data[wcra_pkg::WS_W-1:0];
                wcra_pkg::REG_COVERAGE_THRESHOLD: thr_reg       <= cfg_data[wcra_pkg::THR_W-1:0];
                wcra_pkg::REG_MAX_GAP:            max_gap_reg   <= cfg_data;
                wcra_pkg::REG_GAP_START:          gap_start_reg <= cfg_data;
                wcra_pkg::REG_GAP_END:            gap_end_reg   <= cfg_data;
                wcra_pkg::REG_GENETIC_MODE:       genetic_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pass history ring and sliding-window bookkeeping
    wcra_hist #(
        .WINDOW_MAX (WINDOW_MAX),
        .CW         (CW)
    ) u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (in_accept),
        .wr_bit   (s_pass),
        .wr_first (s_tuser[0]),
        .ws_eff   (ws_eff),
        .rc_start (cfg_accept && (cfg_index == wcra_pkg::REG_WINDOW_SIZE)),
        .old_bit  (old_bit),
        .rc_sum   (rc_sum),
        .rc_stat  (rc_stat)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_accept) begin
            in_vld_reg <= 1'b1;
        end else if (proc_fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_first_reg <= s_tuser[0];
            in_last_reg  <= s_tlast;
            in_phys_reg  <= s_tdata[31:0];
            in_gen_reg   <= s_tdata[63:32];
            in_pass_reg  <= s_pass;
        end
    end

    // Per-locus update: coverage, gap test, run open/close
    always_comb begin
        run_base       = in_first_reg ? 1'b0 : run_active_reg;
        start_pos_base = in_first_reg ? '0 : run_start_pos_reg;
        start_idx_base = in_first_reg ? '0 : run_start_idx_reg;
        locus_base     = in_first_reg ? '0 : locus_idx_reg;
        prev_phys_base = in_first_reg ? '0 : prev_phys_reg;
        prev_rep_base  = in_first_reg ? '0 : prev_rep_reg;
        count_base     = in_first_reg ? '0 : count_reg;

        rep        = genetic_reg ? in_gen_reg : in_phys_reg;
        count_next = CW'(count_base + CW'(in_pass_reg) - CW'(old_bit));
        covered    = 32'(count_next) >= 32'(thr_eff);

        // A backward step never counts as a gap by distance
        phys_step = in_phys_reg - prev_phys_base;
        gap = ((in_phys_reg > prev_phys_base) && (phys_step > max_gap_reg)) ||
              ((gap_start_reg <= prev_phys_base) && (gap_end_reg >= prev_phys_base)) ||
              ((gap_start_reg <= in_phys_reg) && (gap_end_reg >= in_phys_reg)) ||
              ((gap_start_reg >= prev_phys_base) && (gap_end_reg <= in_phys_reg));

        run_next       = run_base;
        start_pos_next = start_pos_base;
        start_idx_next = start_idx_base;
        emit_req       = 1'b0;
        emit_stop      = prev_rep_base;
        emit_len       = locus_base - start_idx_base;

        if (!run_base && covered) begin
            run_next       = 1'b1;
            start_pos_next = rep;
            start_idx_next = locus_base;
        end else if (covered && gap) begin
            // Close at the previous locus, restart here
            emit_req       = 1'b1;
            start_pos_next = rep;
            start_idx_next = locus_base;
        end else if (run_base && !covered) begin
            emit_req = 1'b1;
            run_next = 1'b0;
        end else if (run_base && in_last_reg) begin
            emit_req  = 1'b1;
            emit_stop = rep;
            emit_len  = locus_base - start_idx_base + 32'd1;
            run_next  = 1'b0;
        end

        do_emit = emit_req && (emit_len >= 32'(thr_eff));

        // Size with +1 in physical mode, clamped to the unsigned range
        size_raw = {2'b00, emit_stop} - {2'b00, start_pos_base} +
                   (POS_W+2)'(!genetic_reg);
        if (size_raw[POS_W+1]) begin
            size_sat = '0;
        end else if (size_raw[POS_W]) begin
            size_sat = '1;
        end else begin
            size_sat = size_raw[POS_W-1:0];
        end

        locus_next = locus_base + 32'd1;
    end

    // Sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg         <= '0;
            run_active_reg    <= 1'b0;
            run_start_pos_reg <= '0;
            run_start_idx_reg <= '0;
            locus_idx_reg     <= '0;
            prev_phys_reg     <= '0;
            prev_rep_reg      <= '0;
        end else if (proc_fire) begin
            count_reg         <= count_next;
            run_active_reg    <= run_next;
            run_start_pos_reg <= start_pos_next;
            run_start_idx_reg <= start_idx_next;
            locus_idx_reg     <= locus_next;
            prev_phys_reg     <= in_phys_reg;
            prev_rep_reg      <= rep;
        end else if (rc_stat.load) begin
            count_reg <= rc_sum;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (proc_fire) begin
            out_vld_reg <= do_emit;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && do_emit) begin
            seg_start_reg <= start_pos_base;
            seg_stop_reg  <= emit_stop;
            seg_size_reg  <= size_sat;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {seg_size_reg, seg_stop_reg, seg_start_reg};

`ifndef NO_ASSERTIONS
    // No locus may enter while the history is being recounted
    a_no_accept_in_recount: assert property (@(posedge aclk) disable iff (!aresetn)
        rc_stat.busy |-> !s_tready)
        else $error("locus accepted during history recount");

    // Both registers full and receiver stalled: input must be held off
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_vld_reg && !m_tready) |-> !s_tready)
        else $error("input accepted with both stages full");

    // A result only comes from an open run that was not dropped by a new sequence
    a_emit_from_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && do_emit) |-> (run_active_reg && !in_first_reg))
        else $error("result emitted without an open run");

    // Locus index advances once per processed locus
    a_locus_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire |=> (locus_idx_reg == $past(locus_next)))
        else $error("locus index did not advance");
`endif

endmodule

FILE: hw/rtl/wcra_hist.sv
module wcra_hist #(
    parameter int WINDOW_MAX = wcra_pkg::WINDOW_MAX_DEF,
    parameter int CW         = $clog2(WINDOW_MAX + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic              wr_bit,
    input  logic              wr_first,
    input  logic [CW-1:0]     ws_eff,
    input  logic              rc_start,
    output logic              old_bit,
    output logic [CW-1:0]     rc_sum,
    output wcra_pkg::rc_stat_t rc_stat
);

    localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW1 = CW + 1;

    logic              hist_mem [0:WINDOW_MAX-1];
    logic [AW-1:0]     ptr_reg;
    logic [CW-1:0]     seq_len_reg;
    logic              rd_reg;
    logic              old_vld_reg;
    logic              rc_busy_reg;
    logic              rc_pend_reg;
    logic [CW-1:0]     rc_k_reg;
    logic [CW-1:0]     rc_sum_reg;
    logic [CW-1:0]     rc_n;
    logic              rc_issue;
    logic [CW-1:0]     rd_off;
    logic [AW-1:0]     raddr;

    // Step a slot pointer back by off (1..WINDOW_MAX), wrapping around the ring
    function automatic logic [AW-1:0] ptr_back(input logic [AW-1:0] p,
                                               input logic [CW-1:0] off);
        logic [CW1-1:0] pe;
        logic [CW1-1:0] oe;
        pe = CW1'(p);
        oe = CW1'(off);
        if (pe >= oe) begin
            return AW'(pe - oe);
        end else begin
            return AW'(pe + CW1'(WINDOW_MAX) - oe);
        end
    endfunction

    // Recount covers the entries of the current sequence inside the window
    assign rc_n     = (ws_eff < seq_len_reg) ? ws_eff : seq_len_reg;
    assign rc_issue = rc_busy_reg && (rc_k_reg < rc_n);
    assign rd_off   = rc_busy_reg ? CW'(rc_k_reg + CW'(1)) : ws_eff;
    assign raddr    = ptr_back(ptr_reg, rd_off);

    // Write the new pass bit, read the one leaving the window
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[ptr_reg] <= wr_bit;
        end
        if (wr_en || rc_issue) begin
            rd_reg <= hist_mem[raddr];
        end
    end

    // Ring pointer, sequence fill and recount control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            seq_len_reg <= '0;
            old_vld_reg <= 1'b0;
            rc_busy_reg <= 1'b0;
            rc_pend_reg <= 1'b0;
            rc_k_reg    <= '0;
            rc_sum_reg  <= '0;
        end else begin
            if (wr_en) begin
                old_vld_reg <= !wr_first && (seq_len_reg >= ws_eff);
                if (32'(ptr_reg) == WINDOW_MAX - 1) begin
                    ptr_reg <= '0;
                end else begin
                    ptr_reg <= AW'(ptr_reg + AW'(1));
                end
                if (wr_first) begin
                    seq_len_reg <= CW'(1);
                end else if (32'(seq_len_reg) < WINDOW_MAX) begin
                    seq_len_reg <= CW'(seq_len_reg + CW'(1));
                end
            end
            if (rc_start) begin
                rc_busy_reg <= 1'b1;
                rc_pend_reg <= 1'b0;
                rc_k_reg    <= '0;
                rc_sum_reg  <= '0;
            end else if (rc_busy_reg) begin
                rc_pend_reg <= rc_issue;
                if (rc_issue) begin
                    rc_k_reg <= CW'(rc_k_reg + CW'(1));
                end
                if (rc_pend_reg) begin
                    rc_sum_reg <= CW'(rc_sum_reg + CW'(rd_reg));
                end
                if (!rc_issue && !rc_pend_reg) begin
                    rc_busy_reg <= 1'b0;
                end
            end
        end
    end

    assign old_bit      = rd_reg & old_vld_reg;
    assign rc_sum       = rc_sum_reg;
    assign rc_stat.busy = rc_busy_reg;
    assign rc_stat.load = rc_busy_reg && !rc_issue && !rc_pend_reg;

endmodule
